### rtl/pairwise_time_histogram_table_assert.svh
// assertion macros shared by the checker
`ifndef PAIRWISE_TIME_HISTOGRAM_TABLE_ASSERT_SVH
`define PAIRWISE_TIME_HISTOGRAM_TABLE_ASSERT_SVH

`define PTHT_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

`define PTHT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### rtl/ptht_pkg.sv
package ptht_pkg;

   localparam int unsigned VALUE_BITS = 20;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

   typedef enum logic [2:0] {
      CMD_ADD  = 3'd0,
      CMD_DEL  = 3'd1,
      CMD_INC  = 3'd2,
      CMD_READ = 3'd3,
      CMD_SUM  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EXISTS  = 2'd1,
      ST_MISSING = 2'd2,
      ST_RANGE   = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  source_node;
      logic [3:0]  target_node;
      logic [15:0] rel_time;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [19:0] value;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  source_node;
      logic [3:0]  target_node;
      logic        bin_ok;
      logic [15:0] bin;
   } job_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_EXEC,
      B_INC_WR,
      B_CLR,
      B_RD,
      B_SUM,
      B_SUM_TAIL,
      B_RESP
   } back_state_type;

endpackage

### rtl/ptht_ram.sv
module ptht_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/ptht_front.sv
module ptht_front #(
   parameter int NUM_BINS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptht_pkg::req_type req_item,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata,
   input  logic              q_full,
   output logic              q_push,
   output ptht_pkg::job_type q_job
);

   ptht_pkg::front_state_type state_ff, state_in;
   logic [15:0] width_ff, width_in;
   logic [16:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] div_ff, div_in;
   logic [3:0]  cnt_ff, cnt_in;
   ptht_pkg::req_type item_ff, item_in;
   logic [16:0] rem_sh;
   logic [16:0] rem_sub;

   assign rem_sh  = {rem_ff[15:0], quo_ff[15]};
   assign rem_sub = rem_sh - {1'b0, div_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptht_pkg::F_IDLE: if (start) state_in = ptht_pkg::F_DIV;
         ptht_pkg::F_DIV:  if (cnt_ff == 4'hF) state_in = ptht_pkg::F_PUSH;
         ptht_pkg::F_PUSH: if (!q_full) state_in = ptht_pkg::F_IDLE;
         default:          state_in = ptht_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      width_in = csr_we ? csr_wdata : width_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      cnt_in   = cnt_ff;
      item_in  = item_ff;
      unique case (state_ff)
         ptht_pkg::F_IDLE: begin
            item_in = req_item;
            rem_in  = '0;
            quo_in  = req_item.rel_time;
            div_in  = width_ff;
            cnt_in  = '0;
         end
         ptht_pkg::F_DIV: begin
            cnt_in = cnt_ff + 4'd1;
            if (!rem_sub[16]) begin
               rem_in = rem_sub;
               quo_in = {quo_ff[14:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[14:0], 1'b0};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptht_pkg::F_IDLE;
         width_ff <= 16'd1;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      item_ff <= item_in;
   end

   assign busy   = (state_ff != ptht_pkg::F_IDLE);
   assign q_push = (state_ff == ptht_pkg::F_PUSH) && !q_full;

   always_comb begin
      q_job.cmd         = item_ff.cmd;
      q_job.source_node = item_ff.source_node;
      q_job.target_node = item_ff.target_node;
      q_job.bin         = quo_ff;
      q_job.bin_ok      = (div_ff != 16'd0) && (32'(quo_ff) < NUM_BINS);
   end

endmodule

### rtl/ptht_queue.sv
module ptht_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptht_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output ptht_pkg::job_type pop_job
);

   ptht_pkg::job_type slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] fill_ff, fill_in;

   always_comb begin
      wptr_in = push ? ~wptr_ff : wptr_ff;
      rptr_in = pop ? ~rptr_ff : rptr_ff;
      fill_in = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
      if (push) begin
         slot_ff[wptr_ff] <= push_job;
      end
   end

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign pop_job   = slot_ff[rptr_ff];

endmodule

### rtl/ptht_back.sv
module ptht_back #(
   parameter int MAX_NODES  = 16,
   parameter int NUM_BINS   = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  ptht_pkg::job_type q_job,
   output logic              q_pop,
   output logic              rsp_valid,
   output ptht_pkg::rsp_type rsp_item
);

   localparam int NB   = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int BB   = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int AB   = 2 * NB + BB;
   localparam int ACCB = COUNT_BITS + NB;

   ptht_pkg::back_state_type state_ff, state_in;
   ptht_pkg::job_type cur_ff, cur_in;
   logic [MAX_NODES-1:0]  nv_ff, nv_in;
   logic [(1<<(2*NB))-1:0] pv_ff, pv_in;
   logic [BB-1:0]   bcnt_ff, bcnt_in;
   logic [NB-1:0]   ncnt_ff, ncnt_in;
   logic            take_ff, take_in;
   logic [ACCB-1:0] acc_ff, acc_in;
   logic [1:0]      status_ff, status_in;
   logic [19:0]     value_ff, value_in;

   logic [NB-1:0] sidx, tidx;
   logic [BB-1:0] bidx;
   logic          src_ok, tgt_ok, src_in_range, pair_ok;
   logic [ACCB-1:0] acc_sum;

   logic            ram_we;
   logic [AB-1:0]   ram_waddr, ram_raddr;
   logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

   assign sidx         = NB'(cur_ff.source_node);
   assign tidx         = NB'(cur_ff.target_node);
   assign bidx         = BB'(cur_ff.bin);
   assign src_in_range = (32'(cur_ff.source_node) < MAX_NODES);
   assign src_ok       = src_in_range && nv_ff[sidx];
   assign tgt_ok       = (32'(cur_ff.target_node) < MAX_NODES) && nv_ff[tidx];
   assign pair_ok      = pv_ff[{sidx, tidx}];
   assign acc_sum      = acc_ff + (take_ff ? ACCB'(ram_rdata) : ACCB'(0));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ptht_pkg::B_IDLE: if (q_not_empty) state_in = ptht_pkg::B_EXEC;
         ptht_pkg::B_EXEC: begin
            state_in = ptht_pkg::B_RESP;
            case (cur_ff.cmd)
               ptht_pkg::CMD_INC:
                  if (src_ok && tgt_ok && cur_ff.bin_ok)
                     state_in = pair_ok ? ptht_pkg::B_INC_WR : ptht_pkg::B_CLR;
               ptht_pkg::CMD_READ:
                  if (src_ok && tgt_ok && cur_ff.bin_ok && pair_ok)
                     state_in = ptht_pkg::B_RD;
               ptht_pkg::CMD_SUM:
                  if (src_ok && cur_ff.bin_ok) state_in = ptht_pkg::B_SUM;
               default: ;
            endcase
         end
         ptht_pkg::B_INC_WR: state_in = ptht_pkg::B_RESP;
         ptht_pkg::B_CLR:
            if (bcnt_ff == BB'(NUM_BINS - 1)) state_in = ptht_pkg::B_RESP;
         ptht_pkg::B_RD:     state_in = ptht_pkg::B_RESP;
         ptht_pkg::B_SUM:
            if (ncnt_ff == NB'(MAX_NODES - 1)) state_in = ptht_pkg::B_SUM_TAIL;
         ptht_pkg::B_SUM_TAIL: state_in = ptht_pkg::B_RESP;
         ptht_pkg::B_RESP:   state_in = ptht_pkg::B_IDLE;
         default:            state_in = ptht_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      cur_in    = cur_ff;
      nv_in     = nv_ff;
      pv_in     = pv_ff;
      bcnt_in   = bcnt_ff;
      ncnt_in   = ncnt_ff;
      take_in   = 1'b0;
      acc_in    = acc_ff;
      status_in = status_ff;
      value_in  = value_ff;
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = {sidx, tidx, bidx};
      ram_wdata = '0;
      ram_raddr = {sidx, tidx, bidx};
      unique case (state_ff)
         ptht_pkg::B_IDLE: begin
            q_pop  = q_not_empty;
            cur_in = q_job;
         end
         ptht_pkg::B_EXEC: begin
            status_in = ptht_pkg::ST_OK;
            value_in  = '0;
            bcnt_in   = '0;
            ncnt_in   = '0;
            acc_in    = '0;
            case (cur_ff.cmd)
               ptht_pkg::CMD_ADD: begin
                  if (!src_in_range) status_in = ptht_pkg::ST_MISSING;
                  else if (nv_ff[sidx]) status_in = ptht_pkg::ST_EXISTS;
                  else nv_in[sidx] = 1'b1;
               end
               ptht_pkg::CMD_DEL: begin
                  if (!src_ok) status_in = ptht_pkg::ST_MISSING;
                  else begin
                     nv_in[sidx] = 1'b0;
                     for (int i = 0; i < MAX_NODES; i++) begin
                        pv_in[{sidx, NB'(i)}] = 1'b0;
                        pv_in[{NB'(i), sidx}] = 1'b0;
                     end
                  end
               end
               ptht_pkg::CMD_INC: begin
                  if (!src_ok || !tgt_ok) status_in = ptht_pkg::ST_MISSING;
                  else if (!cur_ff.bin_ok) status_in = ptht_pkg::ST_RANGE;
               end
               ptht_pkg::CMD_READ, ptht_pkg::CMD_SUM: begin
                  if (!src_ok || (cur_ff.cmd == ptht_pkg::CMD_READ && !tgt_ok))
                     status_in = ptht_pkg::ST_MISSING;
               end
               default: ;
            endcase
         end
         ptht_pkg::B_INC_WR: begin
            ram_we    = 1'b1;
            ram_wdata = (ram_rdata == {COUNT_BITS{1'b1}}) ? ram_rdata
                                                          : ram_rdata + 1'b1;
         end
         ptht_pkg::B_CLR: begin
            ram_we    = 1'b1;
            ram_waddr = {sidx, tidx, bcnt_ff};
            ram_wdata = (bcnt_ff == bidx) ? COUNT_BITS'(1) : '0;
            bcnt_in   = bcnt_ff + 1'b1;
            if (bcnt_ff == BB'(NUM_BINS - 1)) pv_in[{sidx, tidx}] = 1'b1;
         end
         ptht_pkg::B_RD: begin
            value_in = (64'(ram_rdata) > 64'(ptht_pkg::VALUE_MAX))
                       ? ptht_pkg::VALUE_MAX : 20'(ram_rdata);
         end
         ptht_pkg::B_SUM: begin
            ram_raddr = {sidx, ncnt_ff, bidx};
            take_in   = nv_ff[ncnt_ff] && pv_ff[{sidx, ncnt_ff}];
            acc_in    = acc_sum;
            ncnt_in   = ncnt_ff + 1'b1;
         end
         ptht_pkg::B_SUM_TAIL: begin
            value_in = (64'(acc_sum) > 64'(ptht_pkg::VALUE_MAX))
                       ? ptht_pkg::VALUE_MAX : 20'(acc_sum);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptht_pkg::B_IDLE;
         nv_ff    <= '0;
         pv_ff    <= '0;
         take_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         nv_ff    <= nv_in;
         pv_ff    <= pv_in;
         take_ff  <= take_in;
      end
      cur_ff    <= cur_in;
      bcnt_ff   <= bcnt_in;
      ncnt_ff   <= ncnt_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
      value_ff  <= value_in;
   end

   ptht_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(1 << AB)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign rsp_valid       = (state_ff == ptht_pkg::B_RESP);
   assign rsp_item.status = status_ff;
   assign rsp_item.value  = value_ff;

endmodule

### rtl/pairwise_time_histogram_table.sv
// channel   ports                          transfer when
// request   start, busy, req_item          start && !busy
// response  rsp_valid, rsp_item            rsp_valid (one cycle, no stall)
// config    csr_we, csr_wdata              csr_we
//
// Front end divides rel_time by bin_width, one quotient bit per cycle. In the back end
// the first increment of a pair clears the pair's NUM_BINS bins, and a row sum walks
// all MAX_NODES nodes.
// Reset clears node and pair valid flags at once; no clearing pass.
// A two-entry queue lets the front take the next request while the back works.
module pairwise_time_histogram_table #(
   parameter int MAX_NODES  = 16,
   parameter int NUM_BINS   = 32,
   parameter int COUNT_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ptht_pkg::req_type req_item,
   output logic              rsp_valid,
   output ptht_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);

   logic              q_full, q_push, q_pop, q_not_empty;
   ptht_pkg::job_type push_job, pop_job;

   ptht_front #(
      .NUM_BINS(NUM_BINS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (push_job)
   );

   ptht_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .not_empty(q_not_empty),
      .pop_job  (pop_job)
   );

   ptht_back #(
      .MAX_NODES (MAX_NODES),
      .NUM_BINS  (NUM_BINS),
      .COUNT_BITS(COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_job      (pop_job),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

endmodule

### rtl/ptht_checker.sv
`include "pairwise_time_histogram_table_assert.svh"

module ptht_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ptht_pkg::rsp_type rsp_item
);

   logic rsp_fail;

   assign rsp_fail = rsp_valid && (rsp_item.status != ptht_pkg::ST_OK);

   `PTHT_ASSERT_NEXT(a_busy_after_accept, start && !busy, busy)
   `PTHT_ASSERT_NEXT(a_rsp_single_cycle, rsp_valid, !rsp_valid)
   `PTHT_ASSERT_IMPL(a_fail_no_value, rsp_fail, rsp_item.value == 20'd0)

endmodule

bind pairwise_time_histogram_table ptht_checker u_chk (.*);

### dv/tb_pairwise_time_histogram_table.sv
module tb_pairwise_time_histogram_table;

   localparam int NODES = 16;
   localparam int BINS = 32;
   localparam int COUNT_MAX = 65535;
   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   ptht_pkg::req_type req_item = '0;
   logic rsp_valid;
   ptht_pkg::rsp_type rsp_item;
   logic csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   always #1 clock = ~clock;

   pairwise_time_histogram_table u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // shadow copy of the table
   logic [15:0]       width_shadow;
   bit                valid_shadow [NODES];
   int unsigned       hist_shadow [NODES][NODES][BINS];
   ptht_pkg::rsp_type expected_rsps [$];
   int                mismatch_count = 0;
   int                cycle_count = 0;
   bit                no_idle = 0;
   int                idle_left = 0;

   task automatic report(input string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   function automatic ptht_pkg::rsp_type histogram_predict(input ptht_pkg::req_type r);
      ptht_pkg::rsp_type o;
      int unsigned bin, acc;
      bit in_range;
      o = '0;
      if (width_shadow == 0) begin
         in_range = 0;
         bin = 0;
      end else begin
         bin = r.rel_time / width_shadow;
         in_range = bin < BINS;
      end
      case (r.cmd)
         ptht_pkg::CMD_ADD: begin
            if (valid_shadow[r.source_node]) o.status = ptht_pkg::ST_EXISTS;
            else valid_shadow[r.source_node] = 1;
         end
         ptht_pkg::CMD_DEL: begin
            if (!valid_shadow[r.source_node]) o.status = ptht_pkg::ST_MISSING;
            else begin
               valid_shadow[r.source_node] = 0;
               for (int i = 0; i < NODES; i++)
                  for (int b = 0; b < BINS; b++) begin
                     hist_shadow[r.source_node][i][b] = 0;
                     hist_shadow[i][r.source_node][b] = 0;
                  end
            end
         end
         ptht_pkg::CMD_INC: begin
            if (!valid_shadow[r.source_node] || !valid_shadow[r.target_node])
               o.status = ptht_pkg::ST_MISSING;
            else if (!in_range) o.status = ptht_pkg::ST_RANGE;
            else if (hist_shadow[r.source_node][r.target_node][bin] < COUNT_MAX)
               hist_shadow[r.source_node][r.target_node][bin]++;
         end
         ptht_pkg::CMD_READ: begin
            if (!valid_shadow[r.source_node] || !valid_shadow[r.target_node])
               o.status = ptht_pkg::ST_MISSING;
            else if (in_range)
               o.value = 20'(hist_shadow[r.source_node][r.target_node][bin]);
         end
         ptht_pkg::CMD_SUM: begin
            if (!valid_shadow[r.source_node]) o.status = ptht_pkg::ST_MISSING;
            else if (in_range) begin
               acc = 0;
               for (int i = 0; i < NODES; i++)
                  if (valid_shadow[i]) acc += hist_shadow[r.source_node][i][bin];
               o.value = (acc > ptht_pkg::VALUE_MAX) ? ptht_pkg::VALUE_MAX : acc[19:0];
            end
         end
         default: ;
      endcase
      return o;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) report("result with nothing expected");
         else begin
            ptht_pkg::rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_item.status !== e.status)
               report($sformatf("status %0d, expected %0d", rsp_item.status, e.status));
            if (rsp_item.value !== e.value)
               report($sformatf("value %0d, expected %0d", rsp_item.value, e.value));
         end
      end
   end

   // one transfer; chk marks a hand-typed expectation
   task automatic send(input ptht_pkg::req_type r, input bit chk = 0,
                       input ptht_pkg::rsp_type want = '0);
      ptht_pkg::rsp_type p;
      if (!no_idle && idle_left == 0 && $urandom_range(0, 5) == 0)
         idle_left = $urandom_range(1, 4);
      if (idle_left > 0) start <= 1'b0;
      while (idle_left > 0) begin
         @(posedge clock);
         idle_left--;
      end
      start <= 1'b1;
      req_item <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      p = histogram_predict(r);
      if (chk && p != want) report("typed expectation differs from prediction");
      expected_rsps.push_back(p);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_width(input logic [15:0] w);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= w;
      @(posedge clock);
      csr_we <= 1'b0;
      width_shadow = w;
      @(posedge clock);
   endtask

   function automatic ptht_pkg::req_type mk(input ptht_pkg::cmd_type c, input int s,
                                            input int t, input int rt);
      ptht_pkg::req_type r;
      r.cmd = c;
      r.source_node = 4'(s);
      r.target_node = 4'(t);
      r.rel_time = 16'(rt);
      return r;
   endfunction

   function automatic ptht_pkg::rsp_type rs(input ptht_pkg::status_type s, input int v);
      ptht_pkg::rsp_type o;
      o.status = s;
      o.value = 20'(v);
      return o;
   endfunction

   typedef struct {
      ptht_pkg::req_type r;
      bit                chk;
      ptht_pkg::rsp_type want;
   } row_type;

   function automatic ptht_pkg::req_type random_req(input int hot);
      ptht_pkg::req_type r;
      int k;
      k = $urandom_range(0, 99);
      r.cmd = (k < 8) ? ptht_pkg::CMD_ADD : (k < 12) ? ptht_pkg::CMD_DEL :
              (k < 60) ? ptht_pkg::CMD_INC : (k < 80) ? ptht_pkg::CMD_READ :
              (k < 97) ? ptht_pkg::CMD_SUM : ptht_pkg::cmd_type'($urandom_range(5, 7));
      r.source_node = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, hot)) : 4'($urandom);
      r.target_node = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, hot)) : 4'($urandom);
      r.rel_time = ($urandom_range(0, 4) != 0) ?
                   16'($urandom_range(0, 40) * width_shadow + $urandom_range(0, 3)) :
                   16'($urandom);
      return r;
   endfunction

   row_type dir_rows [$];
   logic [15:0] widths [6] = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd2048, 16'd100};

   initial begin
      width_shadow = 16'd1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      dir_rows = '{
         '{mk(ptht_pkg::CMD_READ, 0, 0, 0), 1, rs(ptht_pkg::ST_MISSING, 0)},
         '{mk(ptht_pkg::CMD_SUM, 15, 0, 0), 1, rs(ptht_pkg::ST_MISSING, 0)},
         '{mk(ptht_pkg::CMD_DEL, 15, 0, 0), 1, rs(ptht_pkg::ST_MISSING, 0)},
         '{mk(ptht_pkg::CMD_ADD, 0, 0, 0), 1, rs(ptht_pkg::ST_OK, 0)},
         '{mk(ptht_pkg::CMD_ADD, 0, 0, 0), 1, rs(ptht_pkg::ST_EXISTS, 0)},
         '{mk(ptht_pkg::CMD_ADD, 15, 15, 65535), 1, rs(ptht_pkg::ST_OK, 0)},
         '{mk(ptht_pkg::CMD_INC, 0, 0, 0), 0, '0},
         '{mk(ptht_pkg::CMD_INC, 0, 15, 31), 0, '0},
         '{mk(ptht_pkg::CMD_INC, 15, 15, 31), 0, '0},
         '{mk(ptht_pkg::CMD_INC, 0, 15, 32), 1, rs(ptht_pkg::ST_RANGE, 0)},
         '{mk(ptht_pkg::CMD_INC, 0, 7, 3), 1, rs(ptht_pkg::ST_MISSING, 0)},
         '{mk(ptht_pkg::CMD_READ, 0, 0, 0), 1, rs(ptht_pkg::ST_OK, 1)},
         '{mk(ptht_pkg::CMD_READ, 0, 15, 31), 1, rs(ptht_pkg::ST_OK, 1)},
         '{mk(ptht_pkg::CMD_READ, 0, 15, 65535), 1, rs(ptht_pkg::ST_OK, 0)},
         '{mk(ptht_pkg::CMD_SUM, 0, 0, 31), 0, '0},
         '{mk(ptht_pkg::CMD_SUM, 0, 0, 40000), 1, rs(ptht_pkg::ST_OK, 0)},
         '{mk(ptht_pkg::CMD_INC, 15, 0, 0), 0, '0},
         '{mk(ptht_pkg::CMD_DEL, 15, 0, 0), 1, rs(ptht_pkg::ST_OK, 0)},
         '{mk(ptht_pkg::CMD_READ, 0, 15, 31), 1, rs(ptht_pkg::ST_MISSING, 0)},
         '{mk(ptht_pkg::CMD_ADD, 15, 0, 0), 1, rs(ptht_pkg::ST_OK, 0)},
         '{mk(ptht_pkg::CMD_READ, 0, 15, 31), 1, rs(ptht_pkg::ST_OK, 0)},
         '{mk(ptht_pkg::cmd_type'(3'd5), 3, 9, 1234), 1, rs(ptht_pkg::ST_OK, 0)},
         '{mk(ptht_pkg::cmd_type'(3'd7), 15, 15, 65535), 1, rs(ptht_pkg::ST_OK, 0)},
         '{mk(ptht_pkg::cmd_type'(3'd6), 10, 5, 21845), 1, rs(ptht_pkg::ST_OK, 0)}
      };
      foreach (dir_rows[i]) send(dir_rows[i].r, dir_rows[i].chk, dir_rows[i].want);

      // fill every node, then repeat one bin
      write_width(16'd65535);
      for (int n = 1; n < NODES; n++) send(mk(ptht_pkg::CMD_ADD, n, 0, 0));
      repeat (6) send(mk(ptht_pkg::CMD_INC, 1, 2, 65535));
      send(mk(ptht_pkg::CMD_READ, 1, 2, 0));

      for (int ph = 0; ph < 6; ph++) begin
         write_width(widths[ph]);
         for (int i = 0; i < 260; i++) begin
            if (ph == 5 && i > 180) no_idle = 1;
            send(random_req(ph[0] ? 15 : 3));
         end
         if (ph == 2) drain();
      end
      drain();
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
